>>> rtl/core/calendar_field_adjuster_top_defines.svh
// Assertion macros for the calendar field adjuster.
`ifndef CALENDAR_FIELD_ADJUSTER_TOP_DEFINES_SVH
`define CALENDAR_FIELD_ADJUSTER_TOP_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define CFA_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("calendar_field_adjuster: invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define CFA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("calendar_field_adjuster: implication violated");

`endif

>>> rtl/core/cfa_pkg.sv
package cfa_pkg;

  localparam logic [10:0] YearMin   = 11'd2000;
  localparam logic [10:0] YearMax   = 11'd2030;
  localparam logic [3:0]  MonthMin  = 4'd1;
  localparam logic [3:0]  MonthMax  = 4'd12;
  localparam logic [4:0]  DayMin    = 5'd1;
  localparam logic [4:0]  DayMaxAll = 5'd31;
  localparam logic [4:0]  FebLeap   = 5'd29;
  localparam logic [4:0]  FebNorm   = 5'd28;
  localparam logic [4:0]  HourMax   = 5'd23;
  localparam logic [5:0]  MinuteMax = 6'd59;

  localparam logic [4:0] MonthLenTable [13] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [3:0] {
    CmdQuery      = 4'd0,
    CmdMinuteUp   = 4'd1,
    CmdMinuteDown = 4'd2,
    CmdHourUp     = 4'd3,
    CmdHourDown   = 4'd4,
    CmdDayUp      = 4'd5,
    CmdDayDown    = 4'd6,
    CmdMonthUp    = 4'd7,
    CmdMonthDown  = 4'd8,
    CmdYearUp     = 4'd9,
    CmdYearDown   = 4'd10,
    CmdLoad       = 4'd11
  } cmd_e;

  typedef struct packed {
    logic [3:0]  command;
    logic [10:0] load_year;
    logic [3:0]  load_month;
    logic [4:0]  load_day;
    logic [4:0]  load_hour;
    logic [5:0]  load_minute;
  } cfa_in_t;

  typedef struct packed {
    logic [10:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic        leap_flag;
  } cfa_out_t;

  function automatic logic is_leap(input logic [10:0] year);
    return (year[1:0] == 2'd0);
  endfunction

  function automatic logic [4:0] month_len(input logic [10:0] year, input logic [3:0] month);
    logic [4:0] len;
    if ((month < MonthMin) || (month > MonthMax)) begin
      len = DayMaxAll;
    end else if (month == 4'd2) begin
      len = is_leap(year) ? FebLeap : FebNorm;
    end else begin
      len = MonthLenTable[month];
    end
    return len;
  endfunction

endpackage

>>> rtl/core/calendar_field_adjuster_top.sv
// Calendar field adjuster. Holds a date and time (year 2000..2030, month, day, hour, minute)
// and applies one command per input transaction: step a field up or down with wraparound,
// load all fields (saturated to range, day clamped to the month), or query. Every command
// returns one result carrying the date and time after the command plus a leap-year flag
// (year divisible by four). The result is registered after the input transaction is
// accepted (input register, then result register); throughput is one command per cycle
// while the output is not stalled. Unused command codes act as a query.
`include "calendar_field_adjuster_top_defines.svh"

module calendar_field_adjuster_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cfa_pkg::cfa_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cfa_pkg::cfa_out_t out_data_o
);
  import cfa_pkg::*;

  logic        in_valid_q, in_valid_d;
  cfa_in_t     in_data_q;
  logic        out_valid_q, out_valid_d;
  cfa_out_t    out_data_q;

  logic [10:0] year_q, year_d;
  logic [3:0]  month_q, month_d;
  logic [4:0]  day_q, day_d;
  logic [4:0]  hour_q, hour_d;
  logic [5:0]  minute_q, minute_d;

  logic [10:0] ld_year;
  logic [3:0]  ld_month;
  logic [4:0]  ld_hour;
  logic [5:0]  ld_minute;
  logic [4:0]  day_pre;
  logic [4:0]  len;
  logic        accept_in;
  logic        advance;

  assign advance    = in_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign accept_in  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d  = accept_in ? 1'b1 : (advance ? 1'b0 : in_valid_q);
    out_valid_d = advance ? 1'b1 : (out_valid_q && out_stall_i);
  end

  // load value saturation
  always_comb begin
    ld_year   = in_data_q.load_year;
    ld_month  = in_data_q.load_month;
    ld_hour   = in_data_q.load_hour;
    ld_minute = in_data_q.load_minute;
    if (ld_year < YearMin) ld_year = YearMin;
    if (ld_year > YearMax) ld_year = YearMax;
    if (ld_month < MonthMin) ld_month = MonthMin;
    if (ld_month > MonthMax) ld_month = MonthMax;
    if (ld_hour > HourMax) ld_hour = HourMax;
    if (ld_minute > MinuteMax) ld_minute = MinuteMax;
  end

  always_comb begin
    year_d   = year_q;
    month_d  = month_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    unique case (in_data_q.command)
      CmdMinuteUp:   minute_d = (minute_q == MinuteMax) ? 6'd0 : minute_q + 6'd1;
      CmdMinuteDown: minute_d = (minute_q == 6'd0) ? MinuteMax : minute_q - 6'd1;
      CmdHourUp:     hour_d   = (hour_q == HourMax) ? 5'd0 : hour_q + 5'd1;
      CmdHourDown:   hour_d   = (hour_q == 5'd0) ? HourMax : hour_q - 5'd1;
      CmdMonthUp:    month_d  = (month_q == MonthMax) ? MonthMin : month_q + 4'd1;
      CmdMonthDown:  month_d  = (month_q == MonthMin) ? MonthMax : month_q - 4'd1;
      CmdYearUp:     year_d   = (year_q < YearMax) ? year_q + 11'd1 : YearMin;
      CmdYearDown:   year_d   = (year_q > YearMin) ? year_q - 11'd1 : YearMax;
      CmdLoad: begin
        year_d   = ld_year;
        month_d  = ld_month;
        hour_d   = ld_hour;
        minute_d = ld_minute;
      end
      default: ;
    endcase
  end

  // day stepping uses the new month length; unchanged for day commands
  assign len = month_len(year_d, month_d);

  always_comb begin
    day_pre = day_q;
    unique case (in_data_q.command)
      CmdDayUp:   day_pre = (day_q < len) ? day_q + 5'd1 : DayMin;
      CmdDayDown: day_pre = (day_q > DayMin) ? day_q - 5'd1 : len;
      CmdLoad:    day_pre = in_data_q.load_day;
      default: ;
    endcase
    day_d = day_pre;
    if (day_d > len) day_d = len;
    if (day_d < DayMin) day_d = DayMin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      year_q      <= YearMin;
      month_q     <= MonthMin;
      day_q       <= DayMin;
      hour_q      <= 5'd0;
      minute_q    <= 6'd0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        year_q   <= year_d;
        month_q  <= month_d;
        day_q    <= day_d;
        hour_q   <= hour_d;
        minute_q <= minute_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      in_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q.year_out   <= year_d;
      out_data_q.month_out  <= month_d;
      out_data_q.day_out    <= day_d;
      out_data_q.hour_out   <= hour_d;
      out_data_q.minute_out <= minute_d;
      out_data_q.leap_flag  <= is_leap(year_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `CFA_ASSERT_ALWAYS(a_date_range,
                     (year_q >= YearMin) && (year_q <= YearMax) &&
                     (month_q >= MonthMin) && (month_q <= MonthMax))
  `CFA_ASSERT_ALWAYS(a_day_in_month,
                     (day_q >= DayMin) && (day_q <= month_len(year_q, month_q)))
  `CFA_ASSERT_IMPL(a_out_matches_state, out_valid_q,
                   (out_data_q.year_out == year_q) && (out_data_q.day_out == day_q) &&
                   (out_data_q.minute_out == minute_q))

endmodule

>>> dv/tb.sv
module tb;
  import cfa_pkg::*;

  localparam logic [3:0] CmdSpareLo = 4'd12;
  localparam logic [3:0] CmdSpareHi = 4'd15;
  localparam int         PhaseLen   = 230;

  typedef struct {
    cfa_in_t  tx;
    bit       typed;
    cfa_out_t want;
  } date_row_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  cfa_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  cfa_out_t out_data_o;

  // typed expectation travels alongside the payload it belongs to
  bit       row_typed = 1'b0;
  cfa_out_t row_want  = '0;

  cfa_out_t  dates_due[$];
  date_row_t directed_rows[$];
  int        mismatches = 0;
  bit        gaps_on    = 1'b1;
  int        stall_pct  = 30;
  int        stall_left = 0;

  int cal_year   = YearMin;
  int cal_month  = MonthMin;
  int cal_day    = DayMin;
  int cal_hour   = 0;
  int cal_minute = 0;

  calendar_field_adjuster_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int days_in(int y, int m);
    case (m)
      2: begin
        return (y % 4 == 0) ? FebLeap : FebNorm;
      end
      4, 6, 9, 11: begin
        return 30;
      end
      default: begin
        return DayMaxAll;
      end
    endcase
  endfunction

  function automatic cfa_out_t advance_calendar(cfa_in_t tx);
    cfa_out_t res;
    int len;
    len = days_in(cal_year, cal_month);
    case (tx.command)
      CmdMinuteUp:   cal_minute = (cal_minute + 1) % 60;
      CmdMinuteDown: cal_minute = (cal_minute + 59) % 60;
      CmdHourUp:     cal_hour = (cal_hour + 1) % 24;
      CmdHourDown:   cal_hour = (cal_hour + 23) % 24;
      CmdDayUp:      cal_day = (cal_day < len) ? cal_day + 1 : 1;
      CmdDayDown:    cal_day = (cal_day > 1) ? cal_day - 1 : len;
      CmdMonthUp:    cal_month = (cal_month % 12) + 1;
      CmdMonthDown:  cal_month = ((cal_month + 10) % 12) + 1;
      CmdYearUp:     cal_year = (cal_year < YearMax) ? cal_year + 1 : YearMin;
      CmdYearDown:   cal_year = (cal_year > YearMin) ? cal_year - 1 : YearMax;
      CmdLoad: begin
        cal_year   = tx.load_year;
        cal_month  = tx.load_month;
        cal_day    = tx.load_day;
        cal_hour   = tx.load_hour;
        cal_minute = tx.load_minute;
        if (cal_year < YearMin) cal_year = YearMin;
        if (cal_year > YearMax) cal_year = YearMax;
        if (cal_month < MonthMin) cal_month = MonthMin;
        if (cal_month > MonthMax) cal_month = MonthMax;
        if (cal_hour > HourMax) cal_hour = HourMax;
        if (cal_minute > MinuteMax) cal_minute = MinuteMax;
      end
      default: ;
    endcase
    // day is always brought back into the month, a no-op for most commands
    len = days_in(cal_year, cal_month);
    if (cal_day > len) cal_day = len;
    if (cal_day < 1) cal_day = 1;
    res.year_out   = 11'(cal_year);
    res.month_out  = 4'(cal_month);
    res.day_out    = 5'(cal_day);
    res.hour_out   = 5'(cal_hour);
    res.minute_out = 6'(cal_minute);
    res.leap_flag  = (cal_year % 4 == 0);
    return res;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic cfa_in_t cmd_tx(logic [3:0] c);
    cfa_in_t tx;
    tx.command     = c;
    tx.load_year   = 11'($urandom);
    tx.load_month  = 4'($urandom);
    tx.load_day    = 5'($urandom);
    tx.load_hour   = 5'($urandom);
    tx.load_minute = 6'($urandom);
    return tx;
  endfunction

  function automatic cfa_in_t load_tx(int y, int m, int d, int h, int n);
    cfa_in_t tx;
    tx.command     = CmdLoad;
    tx.load_year   = 11'(y);
    tx.load_month  = 4'(m);
    tx.load_day    = 5'(d);
    tx.load_hour   = 5'(h);
    tx.load_minute = 6'(n);
    return tx;
  endfunction

  function automatic cfa_out_t date_of(int y, int m, int d, int h, int n, bit l);
    cfa_out_t res;
    res.year_out   = 11'(y);
    res.month_out  = 4'(m);
    res.day_out    = 5'(d);
    res.hour_out   = 5'(h);
    res.minute_out = 6'(n);
    res.leap_flag  = l;
    return res;
  endfunction

  function automatic cfa_in_t rand_tx();
    cfa_in_t tx;
    int r;
    r  = $urandom_range(0, 99);
    tx = cmd_tx(4'($urandom_range(CmdQuery, CmdYearDown)));
    if (r < 6) begin
      tx.command = 4'($urandom_range(CmdSpareLo, CmdSpareHi));
    end else if (r < 20) begin
      tx.command = CmdLoad;
      if ($urandom_range(0, 3) != 0) begin
        tx.load_year   = 11'($urandom_range(YearMin, YearMax));
        tx.load_month  = 4'($urandom_range(MonthMin, MonthMax));
        tx.load_day    = 5'($urandom_range(0, 1) ? $urandom_range(26, 31)
                                                 : $urandom_range(1, 31));
        tx.load_hour   = 5'($urandom_range(0, HourMax));
        tx.load_minute = 6'($urandom_range(0, MinuteMax));
      end
    end
    return tx;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 200) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic send_date_cmd(cfa_in_t tx, bit typed, cfa_out_t want);
    int gap;
    gap = gaps_on ? idle_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= tx;
    row_typed  <= typed;
    row_want   <= want;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain_dates();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (dates_due.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left  <= idle_len();
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cfa_out_t pred;
    cfa_out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        pred = advance_calendar(in_data_i);
        dates_due.push_back(row_typed ? row_want : pred);
      end
      if (out_valid_o && !out_stall_i) begin
        if (dates_due.size() == 0) begin
          report_mismatch($sformatf("result with none pending: %p", out_data_o));
        end else begin
          want = dates_due.pop_front();
          if (out_data_o.year_out != want.year_out)
            report_mismatch($sformatf("year %0d, want %0d", out_data_o.year_out,
                                      want.year_out));
          if (out_data_o.month_out != want.month_out)
            report_mismatch($sformatf("month %0d, want %0d", out_data_o.month_out,
                                      want.month_out));
          if (out_data_o.day_out != want.day_out)
            report_mismatch($sformatf("day %0d, want %0d", out_data_o.day_out,
                                      want.day_out));
          if (out_data_o.hour_out != want.hour_out)
            report_mismatch($sformatf("hour %0d, want %0d", out_data_o.hour_out,
                                      want.hour_out));
          if (out_data_o.minute_out != want.minute_out)
            report_mismatch($sformatf("minute %0d, want %0d", out_data_o.minute_out,
                                      want.minute_out));
          if (out_data_o.leap_flag != want.leap_flag)
            report_mismatch($sformatf("leap %0b, want %0b", out_data_o.leap_flag,
                                      want.leap_flag));
        end
      end
    end
  end

  initial begin
    date_row_t row;
    int phase;
    int i;

    // walk every field through its wrap from the reset date
    directed_rows.push_back('{cmd_tx(CmdQuery), 1'b1, date_of(2000, 1, 1, 0, 0, 1'b1)});
    directed_rows.push_back('{cmd_tx(CmdMinuteDown), 1'b1, date_of(2000, 1, 1, 0, 59, 1'b1)});
    directed_rows.push_back('{cmd_tx(CmdMinuteUp), 1'b1, date_of(2000, 1, 1, 0, 0, 1'b1)});
    directed_rows.push_back('{cmd_tx(CmdHourDown), 1'b1, date_of(2000, 1, 1, 23, 0, 1'b1)});
    directed_rows.push_back('{cmd_tx(CmdHourUp), 1'b1, date_of(2000, 1, 1, 0, 0, 1'b1)});
    directed_rows.push_back('{cmd_tx(CmdDayDown), 1'b1, date_of(2000, 1, 31, 0, 0, 1'b1)});
    directed_rows.push_back('{cmd_tx(CmdDayUp), 1'b1, date_of(2000, 1, 1, 0, 0, 1'b1)});
    directed_rows.push_back('{cmd_tx(CmdMonthDown), 1'b1, date_of(2000, 12, 1, 0, 0, 1'b1)});
    directed_rows.push_back('{cmd_tx(CmdMonthUp), 1'b1, date_of(2000, 1, 1, 0, 0, 1'b1)});
    directed_rows.push_back('{cmd_tx(CmdYearDown), 1'b1, date_of(2030, 1, 1, 0, 0, 1'b0)});
    directed_rows.push_back('{cmd_tx(CmdYearUp), 1'b1, date_of(2000, 1, 1, 0, 0, 1'b1)});
    // load saturation at both ends of year, month and day, and at the top of hour and minute
    directed_rows.push_back('{load_tx(2047, 15, 31, 31, 63), 1'b1,
                              date_of(2030, 12, 31, 23, 59, 1'b0)});
    directed_rows.push_back('{load_tx(0, 0, 0, 0, 0), 1'b1,
                              date_of(2000, 1, 1, 0, 0, 1'b1)});
    // day clamps to the month length; february length follows the year
    directed_rows.push_back('{load_tx(2024, 2, 31, 12, 30), 1'b1,
                              date_of(2024, 2, 29, 12, 30, 1'b1)});
    directed_rows.push_back('{cmd_tx(CmdYearUp), 1'b1, date_of(2025, 2, 28, 12, 30, 1'b0)});
    directed_rows.push_back('{cmd_tx(CmdDayUp), 1'b0, '0});
    directed_rows.push_back('{cmd_tx(CmdDayDown), 1'b0, '0});
    directed_rows.push_back('{load_tx(2023, 1, 31, 10, 5), 1'b1,
                              date_of(2023, 1, 31, 10, 5, 1'b0)});
    directed_rows.push_back('{cmd_tx(CmdMonthUp), 1'b1, date_of(2023, 2, 28, 10, 5, 1'b0)});
    directed_rows.push_back('{load_tx(2000, 3, 31, 0, 0), 1'b1,
                              date_of(2000, 3, 31, 0, 0, 1'b1)});
    directed_rows.push_back('{cmd_tx(CmdMonthDown), 1'b1, date_of(2000, 2, 29, 0, 0, 1'b1)});
    directed_rows.push_back('{load_tx(2029, 4, 31, 23, 59), 1'b1,
                              date_of(2029, 4, 30, 23, 59, 1'b0)});
    // spare codes leave the date alone
    directed_rows.push_back('{cmd_tx(CmdSpareLo), 1'b1,
                              date_of(2029, 4, 30, 23, 59, 1'b0)});
    directed_rows.push_back('{cmd_tx(CmdSpareHi), 1'b1,
                              date_of(2029, 4, 30, 23, 59, 1'b0)});

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_date_cmd(row.tx, row.typed, row.want);
    end

    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin gaps_on = 1'b1; stall_pct = 30; end
        1: begin gaps_on = 1'b0; stall_pct = 0;  end
        2: begin gaps_on = 1'b1; stall_pct = 60; end
        3: begin gaps_on = 1'b0; stall_pct = 25; end
        default: begin gaps_on = 1'b1; stall_pct = 0; end
      endcase
      if (phase == 3) drain_dates();
      for (i = 0; i < PhaseLen; i++) begin
        send_date_cmd(rand_tx(), 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    stall_pct  = 20;
    @(negedge clk_i);
    while (dates_due.size() != 0) @(negedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
